/* rtl/nss_pkg.sv */
// nss_pkg: shared constants, register codes and controller/datapath interface types
// for the nearest segment search block. No dependencies.
package nss_pkg;

  localparam int MAX_SEGMENTS_DEF = 1024;
  localparam int OFFSET_BITS_DEF  = 24;

  localparam int LAT_W       = 31;
  localparam int LON_W       = 32;
  localparam int COS_W       = 17;
  localparam int IDX_W       = 10;
  localparam int DIST_W      = 28;
  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 232;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 32;

  localparam int T_FRAC          = 24;
  localparam int COS_MIN         = 655;
  localparam int COS_MAX         = 65536;
  localparam int MM_PER_UNIT_Q16 = 728727;
  localparam int MM_CONST_W      = 20;
  localparam int DIST_MAX        = 268435455;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_QUERY_LAT = 2'd0,
    REG_QUERY_LON = 2'd1,
    REG_COS_LAT   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic off;
    logic lmul;
    logic rnd;
    logic mulx;
    logic muly;
    logic sum;
    logic cls;
    logic tmul;
    logic prnd;
    logic sqm;
    logic upd;
    logic fin;
    logic mm;
    logic emit;
  } nss_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_busy;
    logic sqrt_busy;
    logic last;
    logic out_busy;
  } nss_sts_t;

endpackage

/* rtl/nss_div.sv */
// nss_div: restoring divider, one quotient bit per cycle.
// Shifts numerator bits into a preloaded remainder. No package dependency.
module nss_div #(
  parameter int RW = 51,
  parameter int NW = 41,
  parameter int CNTW = $clog2(NW + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [RW-1:0]   divisor,
  input  logic [RW-1:0]   rem_init,
  input  logic [NW-1:0]   num_init,
  input  logic [CNTW-1:0] steps,
  output logic            busy,
  output logic [NW-1:0]   quo
);

  logic [RW-1:0]   div_r, rem_r, rem_nxt, rs;
  logic [NW-1:0]   num_r, quo_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r, ge;

  always_comb begin
    rs      = {rem_r[RW-2:0], num_r[NW-1]};
    ge      = (rs >= div_r);
    rem_nxt = ge ? (rs - div_r) : rs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= (steps != '0);
      cnt_r  <= steps;
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNTW'(1);
      if (cnt_r == CNTW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= divisor;
      rem_r <= rem_init;
      num_r <= num_init;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      num_r <= {num_r[NW-2:0], 1'b0};
      quo_r <= {quo_r[NW-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

/* rtl/nss_sqrt.sv */
// nss_sqrt: bit-pair integer square root, one result bit per cycle,
// rounded to nearest at the end. No package dependency.
module nss_sqrt #(
  parameter int XW = 50
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [XW-1:0]   x,
  output logic            busy,
  output logic [XW/2:0]   root
);

  logic [XW-1:0] v_r, r_r, b_r, trial;
  logic          ge;

  always_comb begin
    trial = r_r + b_r;
    ge    = (v_r >= trial);
  end

  // b_r walks down in pairs of bits; it reaching zero ends the pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r <= '0;
    end else if (start) begin
      b_r <= {2'b01, {(XW-2){1'b0}}};
    end else if (b_r != '0) begin
      b_r <= b_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r <= x;
      r_r <= '0;
    end else if (b_r != '0) begin
      if (ge) begin
        v_r <= v_r - trial;
        r_r <= (r_r >> 1) + b_r;
      end else begin
        r_r <= r_r >> 1;
      end
    end
  end

  assign busy = (b_r != '0);
  // remainder above root means the true root is past the half point
  assign root = (XW/2+1)'(r_r) + (XW/2+1)'(v_r > r_r);

endmodule

/* rtl/nss_dp.sv */
// nss_dp: datapath of the nearest segment search: config registers, projection
// arithmetic, best-segment store and output register. Uses nss_pkg, nss_div, nss_sqrt.
module nss_dp #(
  parameter int MAX_SEGMENTS = nss_pkg::MAX_SEGMENTS_DEF,
  parameter int OFFSET_BITS  = nss_pkg::OFFSET_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [nss_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [nss_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic signed [nss_pkg::LAT_W-1:0]     seg_lat1,
  input  logic signed [nss_pkg::LON_W-1:0]     seg_lon1,
  input  logic signed [nss_pkg::LAT_W-1:0]     seg_lat2,
  input  logic signed [nss_pkg::LON_W-1:0]     seg_lon2,
  input  logic                                 last_segment,
  input  nss_pkg::nss_cmd_t                    cmd,
  output nss_pkg::nss_sts_t                    sts,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [nss_pkg::IDX_W-1:0]            best_index,
  output logic [nss_pkg::DIST_W-1:0]           distance_mm,
  output logic signed [nss_pkg::LAT_W-1:0]     snapped_lat,
  output logic signed [nss_pkg::LON_W-1:0]     snapped_lon,
  output logic signed [nss_pkg::LAT_W-1:0]     best_lat1,
  output logic signed [nss_pkg::LON_W-1:0]     best_lon1,
  output logic signed [nss_pkg::LAT_W-1:0]     best_lat2,
  output logic signed [nss_pkg::LON_W-1:0]     best_lon2
);
  import nss_pkg::*;

  localparam int OB    = OFFSET_BITS;
  localparam int DW    = OB + 1;
  localparam int PW    = 2 * OB + 2;
  localparam int SQ_W  = 2 * OB + 2;
  localparam int NUMW  = 2 * OB + 3;
  localparam int RW    = 2 * OB + 3;
  localparam int NW    = OB + 17;
  localparam int CNTW  = $clog2(NW + 1);
  localparam int CW    = $clog2(MAX_SEGMENTS);
  localparam int XIDW  = (CW > IDX_W) ? CW : IDX_W;
  localparam int RT_W  = SQ_W / 2 + 1;
  localparam int MMP_W = RT_W + MM_CONST_W;
  localparam int TP_W  = T_FRAC + DW + 1;
  localparam int LP_W  = LON_W + 1 + COS_W + 1;

  function automatic logic signed [63:0] sat64(input logic signed [63:0] v, input int bits);
    logic signed [63:0] hi, lo;
    hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) sat64 = hi;
    else if (v < lo) sat64 = lo;
    else sat64 = v;
  endfunction

  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] p, input int s);
    logic [63:0] m, r;
    m = (p < 0) ? $unsigned(-p) : $unsigned(p);
    r = (m + (64'd1 << (s - 1))) >> s;
    rnd_shift = (p < 0) ? -$signed(r) : $signed(r);
  endfunction

  // configuration
  logic signed [LAT_W-1:0] qlat_cfg_r;
  logic signed [LON_W-1:0] qlon_cfg_r;
  logic [COS_W-1:0]        cos_cfg_r, cos_cl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlat_cfg_r <= '0;
      qlon_cfg_r <= '0;
      cos_cfg_r  <= COS_W'(COS_MAX);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_QUERY_LAT: qlat_cfg_r <= cfg_wdata[LAT_W-1:0];
        REG_QUERY_LON: qlon_cfg_r <= cfg_wdata[LON_W-1:0];
        REG_COS_LAT:   cos_cfg_r  <= cfg_wdata[COS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cos_cl = (cos_cfg_r < COS_W'(COS_MIN)) ? COS_W'(COS_MIN) :
                  (cos_cfg_r > COS_W'(COS_MAX)) ? COS_W'(COS_MAX) : cos_cfg_r;

  // per-segment registers
  logic signed [LAT_W-1:0] lat1_r, lat2_r, qlat_r;
  logic signed [LON_W-1:0] lon1_r, lon2_r, qlon_r;
  logic [COS_W-1:0]        cos_r;
  logic                    last_r;
  logic signed [LON_W:0]   dlon1_r, dlon2_r;
  logic signed [LP_W-1:0]  plon1_r, plon2_r;
  logic signed [OB-1:0]    ax_r, ay_r, bx_r, by_r;
  logic signed [DW-1:0]    dx_r, dy_r, dx, dy, px_r, py_r;
  logic signed [PW-1:0]    pxx_r, pyy_r, pax_r, pay_r, sxx_r, syy_r;
  logic [SQ_W-1:0]         den_r, sq;
  logic signed [NUMW-1:0]  num_r;
  logic signed [TP_W-1:0]  tdx_r, tdy_r;
  logic [NW-1:0]           div_q;
  logic                    need_div;
  logic signed [63:0]      tmp_a, tmp_b, tmp_c, tmp_d;

  assign dx = DW'(bx_r) - DW'(ax_r);
  assign dy = DW'(by_r) - DW'(ay_r);
  assign need_div = (den_r != '0) && (num_r > 0) && (num_r < $signed({1'b0, den_r}));

  always_comb begin
    tmp_a = sat64(64'(lat1_r) - 64'(qlat_r), OB);
    tmp_b = sat64(64'(lat2_r) - 64'(qlat_r), OB);
    tmp_c = sat64(rnd_shift(64'(plon1_r), 16), OB);
    tmp_d = sat64(rnd_shift(64'(plon2_r), 16), OB);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lat1_r <= seg_lat1;
      lon1_r <= seg_lon1;
      lat2_r <= seg_lat2;
      lon2_r <= seg_lon2;
      last_r <= last_segment;
      qlat_r <= qlat_cfg_r;
      qlon_r <= qlon_cfg_r;
      cos_r  <= cos_cl;
    end
    if (cmd.off) begin
      ay_r    <= tmp_a[OB-1:0];
      by_r    <= tmp_b[OB-1:0];
      dlon1_r <= (LON_W+1)'(lon1_r) - (LON_W+1)'(qlon_r);
      dlon2_r <= (LON_W+1)'(lon2_r) - (LON_W+1)'(qlon_r);
    end
    if (cmd.lmul) begin
      plon1_r <= dlon1_r * $signed({1'b0, cos_r});
      plon2_r <= dlon2_r * $signed({1'b0, cos_r});
    end
    if (cmd.rnd) begin
      ax_r <= tmp_c[OB-1:0];
      bx_r <= tmp_d[OB-1:0];
    end
    if (cmd.mulx) begin
      dx_r  <= dx;
      pxx_r <= PW'(dx) * PW'(dx);
      pax_r <= PW'(ax_r) * PW'(dx);
    end
    if (cmd.muly) begin
      dy_r  <= dy;
      pyy_r <= PW'(dy) * PW'(dy);
      pay_r <= PW'(ay_r) * PW'(dy);
    end
    if (cmd.sum) begin
      den_r <= $unsigned(pxx_r) + $unsigned(pyy_r);
      num_r <= -(NUMW'(pax_r) + NUMW'(pay_r));
    end
    // endpoints without division: before the first or past the second
    if (cmd.cls && !need_div) begin
      if (den_r == '0 || num_r <= 0) begin
        px_r <= DW'(ax_r);
        py_r <= DW'(ay_r);
      end else begin
        px_r <= DW'(bx_r);
        py_r <= DW'(by_r);
      end
    end
    if (cmd.tmul) begin
      tdx_r <= $signed({1'b0, div_q[T_FRAC-1:0]}) * TP_W'(dx_r);
      tdy_r <= $signed({1'b0, div_q[T_FRAC-1:0]}) * TP_W'(dy_r);
    end
    if (cmd.prnd) begin
      px_r <= DW'(64'(ax_r) + rnd_shift(64'(tdx_r), T_FRAC));
      py_r <= DW'(64'(ay_r) + rnd_shift(64'(tdy_r), T_FRAC));
    end
    if (cmd.sqm) begin
      sxx_r <= PW'(px_r) * PW'(px_r);
      syy_r <= PW'(py_r) * PW'(py_r);
    end
  end

  assign sq = $unsigned(sxx_r) + $unsigned(syy_r);

  // best-segment store
  logic [CW-1:0]           cnt_r, best_pos_r;
  logic [SQ_W-1:0]         best_sq_r;
  logic signed [LAT_W-1:0] best_slat_r, b_lat1_r, b_lat2_r;
  logic signed [LON_W-1:0] best_qlon_r, b_lon1_r, b_lon2_r;
  logic signed [DW-1:0]    best_px_r;
  logic [COS_W-1:0]        best_cos_r;
  logic signed [63:0]      slat_sat;

  assign slat_sat = sat64(64'(qlat_r) + 64'(py_r), LAT_W);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.emit) begin
      cnt_r <= '0;
    end else if (cmd.upd && cnt_r < CW'(MAX_SEGMENTS - 1)) begin
      cnt_r <= cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd && (cnt_r == '0 || sq < best_sq_r)) begin
      best_sq_r   <= sq;
      best_slat_r <= slat_sat[LAT_W-1:0];
      best_px_r   <= px_r;
      best_cos_r  <= cos_r;
      best_qlon_r <= qlon_r;
      b_lat1_r    <= lat1_r;
      b_lon1_r    <= lon1_r;
      b_lat2_r    <= lat2_r;
      b_lon2_r    <= lon2_r;
      best_pos_r  <= cnt_r;
    end
  end

  // shared divider: t fraction per segment, longitude rescale at run end
  logic [DW-1:0]   px_mag;
  logic [NW-1:0]   lon_num;
  logic [RW-1:0]   div_d, div_rem0;
  logic [NW-1:0]   div_n0;
  logic [CNTW-1:0] div_steps;
  logic            div_start, div_busy;

  assign px_mag  = (best_px_r < 0) ? $unsigned(-best_px_r) : $unsigned(best_px_r);
  assign lon_num = {px_mag[NW-17:0], 16'd0} + NW'(best_cos_r >> 1);

  always_comb begin
    div_start = cmd.fin | (cmd.cls & need_div);
    if (cmd.fin) begin
      div_d     = RW'(best_cos_r);
      div_rem0  = '0;
      div_n0    = lon_num;
      div_steps = CNTW'(NW);
    end else begin
      div_d     = RW'(den_r);
      div_rem0  = $unsigned(num_r);
      div_n0    = '0;
      div_steps = CNTW'(T_FRAC);
    end
  end

  nss_div #(.RW(RW), .NW(NW), .CNTW(CNTW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (div_d),
    .rem_init (div_rem0),
    .num_init (div_n0),
    .steps    (div_steps),
    .busy     (div_busy),
    .quo      (div_q)
  );

  logic [RT_W-1:0] root;
  logic            sqrt_busy;

  nss_sqrt #(.XW(SQ_W)) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.fin),
    .x     (best_sq_r),
    .busy  (sqrt_busy),
    .root  (root)
  );

  // result assembly
  logic [MMP_W-1:0]        mmp_r, mm_val;
  logic signed [LON_W-1:0] slon_r;
  logic signed [63:0]      slon_sat;

  assign slon_sat = (best_px_r < 0) ? sat64(64'(best_qlon_r) - $signed(64'(div_q)), LON_W)
                                    : sat64(64'(best_qlon_r) + $signed(64'(div_q)), LON_W);
  assign mm_val   = (mmp_r + MMP_W'(32768)) >> 16;

  always_ff @(posedge clk) begin
    if (cmd.mm) begin
      mmp_r  <= MMP_W'(root) * MMP_W'(MM_PER_UNIT_Q16);
      slon_r <= slon_sat[LON_W-1:0];
    end
  end

  logic                    out_valid_r;
  logic [IDX_W-1:0]        o_idx_r;
  logic [DIST_W-1:0]       o_dist_r;
  logic signed [LAT_W-1:0] o_slat_r, o_lat1_r, o_lat2_r;
  logic signed [LON_W-1:0] o_slon_r, o_lon1_r, o_lon2_r;
  logic [XIDW-1:0]         pos_ext;

  assign pos_ext = XIDW'(best_pos_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_idx_r  <= pos_ext[IDX_W-1:0];
      o_dist_r <= (mm_val > MMP_W'(DIST_MAX)) ? DIST_W'(DIST_MAX) : mm_val[DIST_W-1:0];
      o_slat_r <= best_slat_r;
      o_slon_r <= slon_r;
      o_lat1_r <= b_lat1_r;
      o_lon1_r <= b_lon1_r;
      o_lat2_r <= b_lat2_r;
      o_lon2_r <= b_lon2_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign best_index  = o_idx_r;
  assign distance_mm = o_dist_r;
  assign snapped_lat = o_slat_r;
  assign snapped_lon = o_slon_r;
  assign best_lat1   = o_lat1_r;
  assign best_lon1   = o_lon1_r;
  assign best_lat2   = o_lat2_r;
  assign best_lon2   = o_lon2_r;

  assign sts.need_div  = need_div;
  assign sts.div_busy  = div_busy;
  assign sts.sqrt_busy = sqrt_busy;
  assign sts.last      = last_r;
  assign sts.out_busy  = out_valid_r & ~out_ready;

endmodule

/* rtl/nss_ctrl.sv */
// nss_ctrl: sequencer of the nearest segment search; steps the datapath
// through one segment and the end-of-run result. Uses nss_pkg.
module nss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  nss_pkg::nss_sts_t sts,
  output nss_pkg::nss_cmd_t cmd
);
  import nss_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE = 17'b00000000000000001,
    S_OFF  = 17'b00000000000000010,
    S_LMUL = 17'b00000000000000100,
    S_RND  = 17'b00000000000001000,
    S_MULX = 17'b00000000000010000,
    S_MULY = 17'b00000000000100000,
    S_SUM  = 17'b00000000001000000,
    S_CLS  = 17'b00000000010000000,
    S_DIVT = 17'b00000000100000000,
    S_TMUL = 17'b00000001000000000,
    S_PRND = 17'b00000010000000000,
    S_SQM  = 17'b00000100000000000,
    S_UPD  = 17'b00001000000000000,
    S_FIN  = 17'b00010000000000000,
    S_FINW = 17'b00100000000000000,
    S_MM   = 17'b01000000000000000,
    S_OUT  = 17'b10000000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_OFF;
        end
      end
      S_OFF: begin
        cmd.off   = 1'b1;
        state_nxt = S_LMUL;
      end
      S_LMUL: begin
        cmd.lmul  = 1'b1;
        state_nxt = S_RND;
      end
      S_RND: begin
        cmd.rnd   = 1'b1;
        state_nxt = S_MULX;
      end
      S_MULX: begin
        cmd.mulx  = 1'b1;
        state_nxt = S_MULY;
      end
      S_MULY: begin
        cmd.muly  = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_CLS;
      end
      S_CLS: begin
        cmd.cls   = 1'b1;
        state_nxt = sts.need_div ? S_DIVT : S_SQM;
      end
      S_DIVT: begin
        if (!sts.div_busy) state_nxt = S_TMUL;
      end
      S_TMUL: begin
        cmd.tmul  = 1'b1;
        state_nxt = S_PRND;
      end
      S_PRND: begin
        cmd.prnd  = 1'b1;
        state_nxt = S_SQM;
      end
      S_SQM: begin
        cmd.sqm   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = sts.last ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_FINW;
      end
      S_FINW: begin
        if (!sts.div_busy && !sts.sqrt_busy) state_nxt = S_MM;
      end
      S_MM: begin
        cmd.mm    = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the previous result has left the output register
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* rtl/nearest_segment_search.sv */
// nearest_segment_search: top level; finds the segment of a run nearest to a
// configured query point. Uses nss_pkg, nss_ctrl, nss_dp.
//
// Usage: write query_lat (index 0), query_lon (1) and cos_lat_q16 (2) through
// the cfg port while the block is idle, then stream segments on in_*, with
// in_tlast on the final segment of a run. After that segment one result
// transaction appears on out_*: index, distance in mm, snapped point and the
// endpoints of the nearest segment; earlier segments give no output.
// Segments are handled one at a time. A segment whose projection falls before
// the first or past the second endpoint needs no division; one that projects
// inside waits for the 24-step restoring divider that forms the projection
// fraction. The last segment of a run adds the longitude rescale division,
// which runs in parallel with the square root.
// A finished result waits in the output register; a new run is accepted
// meanwhile, and only the next result waits for out_tready.
// Reset (rst_n low, synchronous) clears the config to 0, 0, 65536, empties the
// output register and starts a new run.
module nearest_segment_search #(
  parameter int MAX_SEGMENTS = nss_pkg::MAX_SEGMENTS_DEF,
  parameter int OFFSET_BITS  = nss_pkg::OFFSET_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [nss_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [nss_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // seg_lat1, seg_lon1, seg_lat2, seg_lon2, zero pad
  input  logic [nss_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // best_index, distance_mm, snapped_lat, snapped_lon,
  // best_lat1, best_lon1, best_lat2, best_lon2, zero pad
  output logic [nss_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import nss_pkg::*;

  nss_cmd_t cmd;
  nss_sts_t sts;

  logic [IDX_W-1:0]        o_idx;
  logic [DIST_W-1:0]       o_dist;
  logic signed [LAT_W-1:0] o_slat, o_lat1, o_lat2;
  logic signed [LON_W-1:0] o_slon, o_lon1, o_lon2;

  nss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nss_dp #(.MAX_SEGMENTS(MAX_SEGMENTS), .OFFSET_BITS(OFFSET_BITS)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .seg_lat1     (in_tdata[30:0]),
    .seg_lon1     (in_tdata[62:31]),
    .seg_lat2     (in_tdata[93:63]),
    .seg_lon2     (in_tdata[125:94]),
    .last_segment (in_tlast),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .best_index   (o_idx),
    .distance_mm  (o_dist),
    .snapped_lat  (o_slat),
    .snapped_lon  (o_slon),
    .best_lat1    (o_lat1),
    .best_lon1    (o_lon1),
    .best_lat2    (o_lat2),
    .best_lon2    (o_lon2)
  );

  assign out_tdata = {5'd0, o_lon2, o_lat2, o_lon1, o_lat1, o_slon, o_slat, o_dist, o_idx};

  // one segment in flight: nothing accepted right after an acceptance
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("segment accepted while previous one in progress");

  // no acceptance while the divider works
  assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_busy |-> !in_tready)
    else $error("input ready during division");

  // square root starts with the longer rescale division and ends first
  assert property (@(posedge clk) disable iff (!rst_n)
    sts.sqrt_busy |-> sts.div_busy)
    else $error("square root outlived the rescale division");

  // a result is only loaded from the output-wait state once the register is free
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_tvalid && !out_tready))
    else $error("result overwrote a pending transaction");

endmodule

/* tb/tb_nearest_segment_search.sv */
// tb_nearest_segment_search: self-checking testbench for the nearest segment search block.
// Needs nss_pkg and nearest_segment_search; predicts each result in SystemVerilog and
// checks every out_* transaction against it.
`timescale 1ns / 100ps

module tb_nearest_segment_search;
  import nss_pkg::*;

  typedef struct {
    bit [LAT_W-1:0] lat1;
    bit [LON_W-1:0] lon1;
    bit [LAT_W-1:0] lat2;
    bit [LON_W-1:0] lon2;
    bit             last;
  } segment_t;

  typedef struct {
    bit [IDX_W-1:0]  index;
    bit [DIST_W-1:0] dist_mm;
    bit [LAT_W-1:0]  snap_lat;
    bit [LON_W-1:0]  snap_lon;
    bit [LAT_W-1:0]  lat1;
    bit [LON_W-1:0]  lon1;
    bit [LAT_W-1:0]  lat2;
    bit [LON_W-1:0]  lon2;
  } nearest_t;

  localparam int  OFF_BITS  = OFFSET_BITS_DEF;
  localparam int  DRAIN     = OFFSET_BITS_DEF + 80;
  localparam int  CYC_LIMIT = 1000000;
  localparam longint BEST_INIT = (64'd1 << 50) - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // predictor state
  bit [LAT_W-1:0] q_lat;
  bit [LON_W-1:0] q_lon;
  bit [COS_W-1:0] q_cos;
  longint best_sq;
  longint best_snap_lat, best_snap_lon;
  segment_t best_seg;
  int best_pos;
  int seg_count;

  nearest_t nearest_q[$];
  bit failed = 1'b0;
  bit no_idle = 1'b0;
  int cycles = 0;

  nearest_segment_search DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk)
    out_tready <= no_idle || ($urandom_range(99) >= 21);

  function automatic longint clamp(longint v, int bits);
    longint hi, lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint rshift_round(longint p, int s);
    longint m;
    m = p < 0 ? -p : p;
    m = (m + (64'sd1 <<< (s - 1))) >>> s;
    return p < 0 ? -m : m;
  endfunction

  function automatic longint div_round(longint n, longint d);
    longint m;
    m = n < 0 ? -n : n;
    m = (m + d / 2) / d;
    return n < 0 ? -m : m;
  endfunction

  function automatic longint sqrt_round(longint x);
    longint r;
    r = 0;
    for (int i = 26; i >= 0; i--)
      if ((r | (64'sd1 <<< i)) * (r | (64'sd1 <<< i)) <= x) r = r | (64'sd1 <<< i);
    if (x - r * r > r) r++;
    return r;
  endfunction

  function automatic longint east_offset(bit [LON_W-1:0] lon, longint cosv);
    return clamp(rshift_round(($signed(lon) - longint'($signed(q_lon))) * cosv, 16),
                 OFF_BITS);
  endfunction

  task automatic reset_run();
    best_sq = BEST_INIT;
    best_snap_lat = 0;
    best_snap_lon = 0;
    best_seg = '{default: 0};
    best_pos = 0;
    seg_count = 0;
  endtask

  // projects the query onto one segment and updates the running best
  task automatic project_segment(segment_t s);
    longint qlat, qlon, cosv, ax, ay, bx, by, dx, dy, den, num, px, py, sq, t, rem, mm;
    nearest_t r;
    qlat = $signed(q_lat);
    qlon = $signed(q_lon);
    cosv = q_cos;
    if (cosv < COS_MIN) cosv = COS_MIN;
    if (cosv > COS_MAX) cosv = COS_MAX;
    ax = east_offset(s.lon1, cosv);
    bx = east_offset(s.lon2, cosv);
    ay = clamp(longint'($signed(s.lat1)) - qlat, OFF_BITS);
    by = clamp(longint'($signed(s.lat2)) - qlat, OFF_BITS);
    dx = bx - ax;
    dy = by - ay;
    den = dx * dx + dy * dy;
    num = -(ax * dx + ay * dy);
    if (den == 0 || num <= 0) begin
      px = ax; py = ay;
    end else if (num >= den) begin
      px = bx; py = by;
    end else begin
      rem = num;
      t = 0;
      for (int i = 0; i < T_FRAC; i++) begin
        rem = rem << 1;
        t = t << 1;
        if (rem >= den) begin
          rem -= den;
          t |= 1;
        end
      end
      px = ax + rshift_round(t * dx, T_FRAC);
      py = ay + rshift_round(t * dy, T_FRAC);
    end
    sq = px * px + py * py;
    if (seg_count == 0 || sq < best_sq) begin
      best_sq = sq;
      best_snap_lat = clamp(qlat + py, LAT_W);
      best_snap_lon = clamp(qlon + div_round(px * 65536, cosv), LON_W);
      best_seg = s;
      best_pos = seg_count;
    end
    if (seg_count < MAX_SEGMENTS_DEF - 1) seg_count++;
    if (s.last) begin
      mm = (sqrt_round(best_sq) * MM_PER_UNIT_Q16 + 32768) >>> 16;
      if (mm > DIST_MAX) mm = DIST_MAX;
      r.index = best_pos[IDX_W-1:0];
      r.dist_mm = mm[DIST_W-1:0];
      r.snap_lat = best_snap_lat[LAT_W-1:0];
      r.snap_lon = best_snap_lon[LON_W-1:0];
      r.lat1 = best_seg.lat1;
      r.lon1 = best_seg.lon1;
      r.lat2 = best_seg.lat2;
      r.lon2 = best_seg.lon2;
      nearest_q.push_back(r);
      reset_run();
    end
  endtask

  task automatic compare_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    nearest_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (nearest_q.size() == 0) begin
        $error("result transaction with nothing expected");
        failed = 1'b1;
      end else begin
        w = nearest_q.pop_front();
        compare_field("best_index", w.index, out_tdata[9:0]);
        compare_field("distance_mm", w.dist_mm, out_tdata[37:10]);
        compare_field("snapped_lat", w.snap_lat, out_tdata[68:38]);
        compare_field("snapped_lon", w.snap_lon, out_tdata[100:69]);
        compare_field("best_lat1", w.lat1, out_tdata[131:101]);
        compare_field("best_lon1", w.lon1, out_tdata[163:132]);
        compare_field("best_lat2", w.lat2, out_tdata[194:164]);
        compare_field("best_lon2", w.lon2, out_tdata[226:195]);
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_segment(segment_t s);
    if (!no_idle && $urandom_range(99) < 21) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {2'b00, s.lon2, s.lat2, s.lon1, s.lat1};
    in_tlast = s.last;
    do @(posedge clk); while (!in_tready);
    project_segment(s);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_idle();
    while (nearest_q.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, bit [CFG_DATA_W-1:0] value);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_QUERY_LAT: q_lat = value[LAT_W-1:0];
      REG_QUERY_LON: q_lon = value;
      default:       q_cos = value[COS_W-1:0];
    endcase
  endtask

  task automatic set_query(bit [LAT_W-1:0] lat, bit [LON_W-1:0] lon, bit [COS_W-1:0] cosv);
    wait_idle();
    write_reg(REG_QUERY_LAT, {1'b0, lat});
    write_reg(REG_QUERY_LON, lon);
    write_reg(REG_COS_LAT, {15'd0, cosv});
  endtask

  function automatic segment_t seg(longint lat1, longint lon1, longint lat2, longint lon2,
                                   bit last);
    segment_t s;
    s.lat1 = lat1[LAT_W-1:0];
    s.lon1 = lon1[LON_W-1:0];
    s.lat2 = lat2[LAT_W-1:0];
    s.lon2 = lon2[LON_W-1:0];
    s.last = last;
    return s;
  endfunction

  // mostly near the query, sometimes far enough to saturate, sometimes any bits
  function automatic longint near_coord(longint centre, int w);
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return centre + $signed($urandom_range(4000)) - 2000;
    if (pick < 85) return centre + $signed($urandom_range(2000000)) - 1000000;
    if (pick < 93) return centre + $signed($urandom_range(40000000)) - 20000000;
    return w == LAT_W ? longint'($signed($urandom() >> 1) <<< 0) : longint'($urandom());
  endfunction

  function automatic segment_t random_segment(bit last);
    longint qa, qo;
    qa = $signed(q_lat);
    qo = $signed(q_lon);
    if ($urandom_range(19) == 0)
      return seg($urandom(), $urandom(), $urandom(), $urandom(), last);
    return seg(near_coord(qa, LAT_W), near_coord(qo, LON_W),
               near_coord(qa, LAT_W), near_coord(qo, LON_W), last);
  endfunction

  function automatic bit [COS_W-1:0] random_cos();
    case ($urandom_range(5))
      0: return $urandom_range(654);
      1: return $urandom_range(131071, 65537);
      2: return COS_MIN;
      3: return COS_MAX;
      default: return $urandom_range(65536, 655);
    endcase
  endfunction

  task automatic test_directed();
    // single segments: extremes of every field
    send_segment(seg(900000000, 1800000000, -900000000, -1800000000, 1));
    send_segment(seg(1073741823, 2147483647, -1073741824, -2147483648, 1));
    send_segment(seg(-1073741824, -2147483648, 1073741823, 2147483647, 1));
    // degenerate segment, also away from the query
    send_segment(seg(500, 700, 500, 700, 1));
    // before the first endpoint, inside, past the second
    send_segment(seg(100, 100, 200, 300, 0));
    send_segment(seg(-300, 1000, 300, 1000, 0));
    send_segment(seg(-300, -900, -100, -50, 1));
    // exact tie: first one wins
    send_segment(seg(40, -100, 40, 100, 0));
    send_segment(seg(40, -100, 40, 100, 0));
    send_segment(seg(-40, -100, -40, 100, 1));
    // first segment taken even though far, later nearer one wins
    send_segment(seg(9000000, 9000000, 9000001, 9000001, 0));
    send_segment(seg(10, 10, 20, 20, 1));
    // cosine below and above its range
    set_query(450000000, -1000000000, 0);
    send_segment(seg(450000100, -1000900000, 449999000, -999000000, 1));
    send_segment(seg(450000000, -1000000000 + 2000000000, 450000000, 2147483647, 1));
    set_query(-450000000, 1000000000, 131071);
    send_segment(seg(-450000100, 999990000, -449990000, 1000020000, 1));
    send_segment(seg(-450010000, 1000010000, -449990000, 999990000, 1));
  endtask

  task automatic test_query_extremes();
    set_query(1073741823, 2147483647, COS_MAX);
    send_segment(seg(-1073741824, -2147483648, 1073741823, 2147483647, 1));
    send_segment(random_segment(1));
    set_query(-1073741824, -2147483648, COS_MIN);
    send_segment(seg(1073741823, 2147483647, -1073741824, -2147483648, 1));
    send_segment(random_segment(1));
    set_query(-900000000, 1800000000, 1);
  endtask

  // the run counter saturates, so every late segment shares the top index
  task automatic test_long_run();
    set_query(123456789, -23456789, 40000);
    for (int i = 0; i < 1030; i++) begin
      if (i == 1027)
        send_segment(seg(123456789, -23456789, 123456789, -23456789, 0));
      else
        send_segment(seg(123456789 + 50000 + i, -23456789 - 50000, 123456789 + 60000,
                         -23456789 + 70000, i == 1029));
    end
  endtask

  task automatic test_random_runs(int total);
    int sent, len;
    sent = 0;
    while (sent < total) begin
      if ($urandom_range(5) == 0)
        set_query($signed($urandom_range(1800000000)) - 900000000,
                  $signed($urandom()) % 1800000000, random_cos());
      else if ($urandom_range(9) == 0)
        wait_idle();
      // a stretch with no idling on either side
      no_idle = (sent > total / 3) && (sent < total / 2);
      len = $urandom_range(3) == 0 ? $urandom_range(40, 9) : $urandom_range(8, 1);
      for (int i = 0; i < len; i++) send_segment(random_segment(i == len - 1));
      sent += len;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    q_lat = 0;
    q_lon = 0;
    q_cos = COS_MAX;
    reset_run();
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_query_extremes();
    test_random_runs(250);
    test_long_run();
    test_random_runs(350);
    wait_idle();
    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
